FILE: sv/clifd_pkg.sv
// Shared types and constants for the byte list unit.
// Used by the controller, the datapath, the top level and the port checker.
package clifd_pkg;

    // List capacity and derived widths
    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;

    // Operation codes carried by a request
    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 2'd0,
        OP_FIND      = 2'd1,
        OP_DEL_FIRST = 2'd2,
        OP_DEL_ALL   = 2'd3
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic walk_done;
    } t_status;

endpackage

FILE: sv/clifd_ctrl.sv
// Controller state machine for the byte list unit.
// Depends on clifd_pkg for the command and status structs.
module clifd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  clifd_pkg::t_status i_status,
    output clifd_pkg::t_cmd    o_cmd,
    output logic               o_busy
);
    import clifd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: sv/clifd_dp.sv
// Datapath for the byte list unit: entry memory, walk counters and result registers.
// Depends on clifd_pkg for widths, op codes and the command and status structs.
module clifd_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  clifd_pkg::t_cmd                i_cmd,
    input  logic [clifd_pkg::OP_W-1:0]     i_op,
    input  logic [clifd_pkg::BYTE_W-1:0]   i_value,
    output clifd_pkg::t_status             o_status,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [clifd_pkg::LEN_W-1:0]    o_removed_count,
    output logic [clifd_pkg::LEN_W-1:0]    o_length,
    output logic                           o_overflow
);
    import clifd_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];

    t_op               r_op;
    logic [BYTE_W-1:0] r_value;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_wr;
    logic [CNT_W-1:0]  r_removed;
    logic              r_found;
    logic              r_pv;
    logic [BYTE_W-1:0] r_rd_data;

    logic              r_valid;
    logic              r_found_o;
    logic [LEN_W-1:0]  r_removed_o;
    logic [LEN_W-1:0]  r_length_o;
    logic              r_overflow_o;

    logic              issue;
    logic              match;
    logic              is_del;
    logic              del_hit;
    logic              room;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // Walk control: read one entry a cycle, compare it in the cycle after the read
    assign issue   = (r_idx < r_count);
    assign match   = (r_rd_data == r_value);
    assign is_del  = (r_op == OP_DEL_FIRST) || (r_op == OP_DEL_ALL);
    assign del_hit = match && ((r_op == OP_DEL_ALL) ||
                               ((r_op == OP_DEL_FIRST) && (r_removed == '0)));
    assign room    = (r_count < CNT_W'(DEPTH));

    assign o_status.walk_done = !issue && !r_pv;

    // Select the single write: compaction during the walk, append at finish
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr[ADDR_W-1:0];
        wr_data = r_rd_data;
        if (i_cmd.walk && r_pv && is_del && !del_hit) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish && (r_op == OP_APPEND) && room) begin
            wr_en   = 1'b1;
            wr_addr = r_count[ADDR_W-1:0];
            wr_data = r_value;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.walk && issue) r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
    end

    // Hold the request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_op);
            r_value <= i_value;
        end
    end

    // Advance walk counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_wr      <= '0;
            r_removed <= '0;
            r_found   <= 1'b0;
            r_pv      <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx     <= '0;
            r_wr      <= '0;
            r_removed <= '0;
            r_found   <= 1'b0;
            r_pv      <= 1'b0;
        end else if (i_cmd.walk) begin
            r_pv <= issue;
            if (issue) r_idx <= r_idx + CNT_W'(1);
            if (r_pv) begin
                if (match) r_found <= 1'b1;
                if (del_hit) begin
                    r_removed <= r_removed + CNT_W'(1);
                end else if (is_del) begin
                    r_wr <= r_wr + CNT_W'(1);
                end
            end
        end else if (i_cmd.finish) begin
            if (r_op == OP_APPEND) begin
                if (room) r_count <= r_count + CNT_W'(1);
            end else if (is_del) begin
                r_count <= r_wr;
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_found_o    <= r_found;
            r_removed_o  <= LEN_W'(r_removed);
            r_overflow_o <= (r_op == OP_APPEND) && !room;
            unique case (r_op)
                OP_APPEND:    r_length_o <= room ? LEN_W'(r_count + CNT_W'(1))
                                                 : LEN_W'(r_count);
                OP_FIND:      r_length_o <= LEN_W'(r_count);
                OP_DEL_FIRST,
                OP_DEL_ALL:   r_length_o <= LEN_W'(r_wr);
                default:      r_length_o <= LEN_W'(r_count);
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_found         = r_found_o;
    assign o_removed_count = r_removed_o;
    assign o_length        = r_length_o;
    assign o_overflow      = r_overflow_o;

endmodule

FILE: sv/char_list_insert_find_delete_unit.sv
// Top level of the byte list unit: joins the controller and the datapath.
// Depends on clifd_pkg, clifd_ctrl and clifd_dp.
//
// Keeps an ordered list of up to DEPTH bytes, empty after reset. A request is
// taken when start is high and busy is low; busy then stays high while the
// controller walks the list and finishes the request, longer on a longer list.
// The walk goes over the entry memory, which has one read port and one write
// port: one entry is read each cycle and compared in the cycle after, and on
// deletes kept entries are written back compacted in that compare cycle. The
// result shows on the o_ ports for exactly one cycle with o_valid high, in the
// first cycle that busy is low again, and must be taken then: it is never held.
// A new request may be given in that same cycle.
module char_list_insert_find_delete_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [clifd_pkg::OP_W-1:0]     i_op,
    input  logic [clifd_pkg::BYTE_W-1:0]   i_value,
    output logic                           o_valid,
    output logic                           o_found,
    output logic [clifd_pkg::LEN_W-1:0]    o_removed_count,
    output logic [clifd_pkg::LEN_W-1:0]    o_length,
    output logic                           o_overflow
);
    import clifd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence each request
    clifd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold the list and build the result
    clifd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_value         (i_value),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_removed_count (o_removed_count),
        .o_length        (o_length),
        .o_overflow      (o_overflow)
    );

endmodule

FILE: sv/clifd_chk.sv
// Port-level checker for the byte list unit, bound to the top level.
// Depends on clifd_pkg for the list capacity and field widths.
module clifd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [clifd_pkg::OP_W-1:0]     i_op,
    input logic [clifd_pkg::BYTE_W-1:0]   i_value,
    input logic                           o_valid,
    input logic                           o_found,
    input logic [clifd_pkg::LEN_W-1:0]    o_removed_count,
    input logic [clifd_pkg::LEN_W-1:0]    o_length,
    input logic                           o_overflow
);
    import clifd_pkg::*;

    // An accepted request raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted request");

    // A result shows only once the unit is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Each request gives a single one-cycle strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A dropped append leaves a full list and removes nothing
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            ((o_removed_count == '0) && (o_length == LEN_W'(DEPTH))))
        else $error("overflow flagged on a list that is not full");

endmodule

bind char_list_insert_find_delete_unit clifd_chk u_clifd_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_list_insert_find_delete_unit: a directed table, then random
// bursts. Depends on clifd_pkg and the unit. Results are checked against a shadow copy of the list.
module tb;
    import clifd_pkg::*;

    // Result fields as they appear on the o_ ports
    typedef struct packed {
        logic             found;
        logic [LEN_W-1:0] removed;
        logic [LEN_W-1:0] length;
        logic             overflow;
    } t_list_result;

    // One directed request; pinned rows carry a hand-written result
    typedef struct packed {
        t_op              op;
        logic [BYTE_W-1:0] val;
        logic             pinned;
        t_list_result     want;
    } t_list_row;

    localparam int DIR_ROWS       = 25;
    localparam int RAND_BLOCKS    = 33;
    localparam int BLOCK_ITEMS    = 25;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = DEPTH + 8;
    localparam t_list_result NO_WANT = '0;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op = OP_APPEND;
    logic [BYTE_W-1:0]   i_value = '0;
    logic                o_valid;
    logic                o_found;
    logic [LEN_W-1:0]    o_removed_count;
    logic [LEN_W-1:0]    o_length;
    logic                o_overflow;

    // Shadow of the list and the results still owed by the unit
    logic [BYTE_W-1:0]   shadow_bytes [DEPTH];
    int                  shadow_len = 0;
    t_list_result        pending_list_results [$];

    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int dropped_appends = 0;
    int full_list_hits  = 0;
    int multi_removals  = 0;
    int burst_left      = 0;
    int idle_cycles     = 0;

    char_list_insert_find_delete_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_removed_count (o_removed_count),
        .o_length        (o_length),
        .o_overflow      (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow list and return the result it must produce
    function automatic t_list_result apply_list_op(input t_op op, input logic [BYTE_W-1:0] v);
        t_list_result r;
        int           hit;
        int           keep;
        int           dropped;
        r = '0;
        hit = -1;
        keep = 0;
        dropped = 0;
        for (int i = 0; i < shadow_len; i++) begin
            if (hit < 0 && shadow_bytes[i] == v) hit = i;
        end
        r.found = (hit >= 0);
        case (op)
            OP_APPEND: begin
                if (shadow_len < DEPTH) begin
                    shadow_bytes[shadow_len] = v;
                    shadow_len++;
                end else begin
                    r.overflow = 1'b1;
                end
            end
            OP_DEL_FIRST: begin
                if (hit >= 0) begin
                    for (int i = hit; i < shadow_len - 1; i++)
                        shadow_bytes[i] = shadow_bytes[i + 1];
                    shadow_len--;
                    r.removed = LEN_W'(1);
                end
            end
            OP_DEL_ALL: begin
                for (int i = 0; i < shadow_len; i++) begin
                    if (shadow_bytes[i] == v) begin
                        dropped++;
                    end else begin
                        shadow_bytes[keep] = shadow_bytes[i];
                        keep++;
                    end
                end
                shadow_len = keep;
                r.removed = dropped[LEN_W-1:0];
            end
            default: ;
        endcase
        r.length = shadow_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] list mismatch: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Present a request, hold it until taken, then record what it must return and pace the next
    task automatic issue_request(input t_op op, input logic [BYTE_W-1:0] v,
                                 input logic pinned, input t_list_result want);
        t_list_result predicted;
        start   <= 1'b1;
        i_op    <= op;
        i_value <= v;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = apply_list_op(op, v);
        pending_list_results.push_back(pinned ? want : predicted);
        requests_sent++;
        if (predicted.overflow) dropped_appends++;
        if (predicted.length == DEPTH) full_list_hits++;
        if (predicted.removed > 1) multi_removals++;
        // End the burst with a random gap, sometimes start a long unbroken one
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_list_results.size() != 0) @(posedge i_clk);
    endtask

    // Stimulus: directed table, then random blocks with a fill, drain or mixed bias
    initial begin
        t_list_row         directed_rows [DIR_ROWS];
        logic [BYTE_W-1:0] pool [4];
        int                mode;
        int                pick;
        t_op               op;
        logic [BYTE_W-1:0] v;

        directed_rows = '{
            '{OP_FIND,      8'h00, 1'b1, '{1'b0, 5'd0, 5'd0,  1'b0}},
            '{OP_DEL_FIRST, 8'hFF, 1'b1, '{1'b0, 5'd0, 5'd0,  1'b0}},
            '{OP_DEL_ALL,   8'h80, 1'b1, '{1'b0, 5'd0, 5'd0,  1'b0}},
            '{OP_APPEND,    8'h00, 1'b1, '{1'b0, 5'd0, 5'd1,  1'b0}},
            '{OP_APPEND,    8'hFF, 1'b1, '{1'b0, 5'd0, 5'd2,  1'b0}},
            '{OP_APPEND,    8'h00, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h55, 1'b0, NO_WANT},
            '{OP_APPEND,    8'hAA, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h00, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h01, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h80, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h7F, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h00, 1'b0, NO_WANT},
            '{OP_APPEND,    8'hFE, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h02, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h40, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h00, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h20, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h10, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h33, 1'b1, '{1'b0, 5'd0, 5'd16, 1'b1}},
            '{OP_FIND,      8'hFF, 1'b0, NO_WANT},
            '{OP_DEL_FIRST, 8'hEE, 1'b1, '{1'b0, 5'd0, 5'd16, 1'b0}},
            '{OP_DEL_ALL,   8'h00, 1'b0, NO_WANT},
            '{OP_DEL_FIRST, 8'hFF, 1'b0, NO_WANT},
            '{OP_APPEND,    8'h01, 1'b0, NO_WANT}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            issue_request(directed_rows[k].op, directed_rows[k].val,
                          directed_rows[k].pinned, directed_rows[k].want);
        end
        drain_results();

        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            mode = $urandom_range(0, 2);
            foreach (pool[k]) pool[k] = BYTE_W'($urandom_range(0, 255));
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                // Bias the op mix so the list fills to overflow and drains to empty
                case (mode)
                    0: op = (pick < 70) ? OP_APPEND : t_op'($urandom_range(1, 3));
                    1: op = (pick < 15) ? OP_APPEND : (pick < 30) ? OP_FIND
                          : (pick < 65) ? OP_DEL_FIRST : OP_DEL_ALL;
                    default: op = t_op'($urandom_range(0, 3));
                endcase
                v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 3)]
                                                : BYTE_W'($urandom_range(0, 255));
                issue_request(op, v, 1'b0, NO_WANT);
            end
            if (blk % 8 == 7) drain_results();
        end

        // Wait out the owed results, then watch for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests, %0d results checked, %0d dropped appends,",
                 requests_sent, results_checked, dropped_appends);
        $display("%0d results at full length, %0d multi-entry deletes, %0d mismatches.",
                 full_list_hits, multi_removals, mismatches);
        if (mismatches == 0) begin
            $display("PASS char_list_insert_find_delete_unit");
        end else begin
            $display("FAIL char_list_insert_find_delete_unit");
        end
        $finish;
    end

    // Check each strobed result against the oldest owed one; count stalled cycles
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (i_rst_n) begin
            got = {o_found, o_removed_count, o_length, o_overflow};
            if (o_valid === 1'b1) begin
                if (pending_list_results.size() == 0) begin
                    report_mismatch("result with no request owed, length",
                                    32'(got.length), 32'd0);
                end else begin
                    want = pending_list_results.pop_front();
                    results_checked++;
                    if (got.found !== want.found)
                        report_mismatch("found", 32'(got.found), 32'(want.found));
                    if (got.removed !== want.removed)
                        report_mismatch("removed_count", 32'(got.removed),
                                        32'(want.removed));
                    if (got.length !== want.length)
                        report_mismatch("length", 32'(got.length), 32'(want.length));
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(got.overflow),
                                        32'(want.overflow));
                end
            end else if (o_valid !== 1'b0) begin
                report_mismatch("o_valid unknown", 32'(o_valid), 32'd0);
            end

            if ((start && busy === 1'b0) || o_valid === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no request or result for %0d cycles", idle_cycles);
                $display("FAIL char_list_insert_find_delete_unit");
                $finish;
            end
        end
    end

endmodule
